[sv/dmc_pkg.sv]
package dmc_pkg;

    // Widths of the motif fields on the ports
    localparam int BASES_W     = 32;
    localparam int LENGTH_W    = 5;
    localparam int BASE_W      = 2;
    // The 32-bit base fields carry at most this many bases
    localparam int FIELD_BASES = BASES_W / BASE_W;

    localparam int DEFAULT_MAX_LEN = 16;

    // Number of bases the block really handles for a given maximum
    function automatic int cap_bases(input int max_len);
        int cap;
        cap = (max_len < FIELD_BASES) ? max_len : FIELD_BASES;
        return cap;
    endfunction

endpackage

[sv/dmc_prep.sv]
module dmc_prep
    import dmc_pkg::*;
#(
    parameter int CAP   = DEFAULT_MAX_LEN,
    parameter int LEN_W = $clog2(CAP + 1),
    parameter int KW    = BASE_W * CAP
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BASES_W-1:0]  in_bases,
    input  logic [LENGTH_W-1:0] in_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEN_W-1:0]    out_len,
    output logic                out_empty,
    output logic [KW-1:0]       out_fwd,
    output logic [KW-1:0]       out_rev
);

    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

    logic                valid_reg;
    logic [LEN_W-1:0]    len_reg,   len_next;
    logic                empty_reg, empty_next;
    logic [KW-1:0]       fwd_reg,   fwd_next;
    logic [KW-1:0]       rev_reg,   rev_next;
    logic [BASE_W-1:0]   base_arr [CAP];
    logic [LEN_W-1:0]    idx_full [CAP];

    assign in_ready = !valid_reg || out_ready;

    // Keys hold the first base in the top bits, so that integer order is
    // lexicographic order; bases past the length are zero.
    always_comb begin
        len_next   = (in_length > LENGTH_W'(CAP)) ? LEN_W'(CAP) : in_length[LEN_W-1:0];
        empty_next = (in_length == '0);
        fwd_next   = '0;
        rev_next   = '0;
        for (int j = 0; j < CAP; j++) begin
            base_arr[j] = in_bases[BASE_W*j +: BASE_W];
            idx_full[j] = len_next - LEN_W'(1) - LEN_W'(j);
        end
        for (int j = 0; j < CAP; j++) begin
            if (LEN_W'(j) < len_next) begin
                fwd_next[KW-1-BASE_W*j -: BASE_W] = base_arr[j];
                rev_next[KW-1-BASE_W*j -: BASE_W] = ~base_arr[idx_full[j][IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            len_reg   <= len_next;
            empty_reg <= empty_next;
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_empty = empty_reg;
    assign out_fwd   = fwd_reg;
    assign out_rev   = rev_reg;

endmodule

[sv/dmc_cell.sv]
module dmc_cell
    import dmc_pkg::*;
#(
    parameter int K     = 0,
    parameter int CAP   = DEFAULT_MAX_LEN,
    parameter int LEN_W = $clog2(CAP + 1),
    parameter int KW    = BASE_W * CAP
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [LEN_W-1:0] in_len,
    input  logic             in_empty,
    input  logic [KW-1:0]    in_fwd,
    input  logic [KW-1:0]    in_rev,
    input  logic [KW-1:0]    in_best,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [LEN_W-1:0] out_len,
    output logic             out_empty,
    output logic [KW-1:0]    out_fwd,
    output logic [KW-1:0]    out_rev,
    output logic [KW-1:0]    out_best
);

    logic             valid_reg;
    logic [LEN_W-1:0] len_reg;
    logic             empty_reg;
    logic [KW-1:0]    fwd_reg,  fwd_next;
    logic [KW-1:0]    rev_reg,  rev_next;
    logic [KW-1:0]    best_reg, best_next;
    logic [KW-1:0]    best_mid;

    assign in_ready = !valid_reg || out_ready;

    // This cell owns rotation K of both strands; it folds them into the
    // running minimum and hands on both strands rotated by one more base.
    always_comb begin
        best_mid  = in_best;
        best_next = in_best;
        if (in_len > LEN_W'(K)) begin
            best_mid  = (in_fwd < in_best)  ? in_fwd : in_best;
            best_next = (in_rev < best_mid) ? in_rev : best_mid;
        end
        fwd_next = '0;
        rev_next = '0;
        for (int j = 0; j < CAP - 1; j++) begin
            if (LEN_W'(j + 1) < in_len) begin
                fwd_next[KW-1-BASE_W*j -: BASE_W] = in_fwd[KW-1-BASE_W*(j+1) -: BASE_W];
                rev_next[KW-1-BASE_W*j -: BASE_W] = in_rev[KW-1-BASE_W*(j+1) -: BASE_W];
            end
        end
        for (int j = 0; j < CAP; j++) begin
            if (LEN_W'(j + 1) == in_len) begin
                fwd_next[KW-1-BASE_W*j -: BASE_W] = in_fwd[KW-1 -: BASE_W];
                rev_next[KW-1-BASE_W*j -: BASE_W] = in_rev[KW-1 -: BASE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            len_reg   <= in_len;
            empty_reg <= in_empty;
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
            best_reg  <= best_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_len   = len_reg;
    assign out_empty = empty_reg;
    assign out_fwd   = fwd_reg;
    assign out_rev   = rev_reg;
    assign out_best  = best_reg;

endmodule

[sv/dna_motif_canonicalizer.sv]
// Channel | Ports                                   | Word
// --------+-----------------------------------------+---------------------------------
// input   | s_valid, s_ready                        | s_motif_bases, s_motif_length
// result  | m_valid, m_ready                        | m_canonical_bases, m_empty_motif
//
// One word is accepted per cycle unless m_ready holds the pipeline; a result passes through
// one preparation stage and one cell per rotation, CAP = min(MAX_MOTIF_LEN, 16).
// Each stage holds its own word and advances when the stage after it is empty or
// moving, so bubbles close up while a finished result waits for m_ready.
// Reset (aresetn low at a clock edge) empties every stage; no data is cleared.
module dna_motif_canonicalizer
    import dmc_pkg::*;
#(
    parameter int MAX_MOTIF_LEN = DEFAULT_MAX_LEN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BASES_W-1:0]  s_motif_bases,
    input  logic [LENGTH_W-1:0] s_motif_length,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BASES_W-1:0]  m_canonical_bases,
    output logic                m_empty_motif
);

    localparam int CAP   = cap_bases(MAX_MOTIF_LEN);
    localparam int LEN_W = $clog2(CAP + 1);
    localparam int KW    = BASE_W * CAP;

    logic             stg_valid [CAP+1];
    logic             stg_ready [CAP+1];
    logic [LEN_W-1:0] stg_len   [CAP+1];
    logic             stg_empty [CAP+1];
    logic [KW-1:0]    stg_fwd   [CAP+1];
    logic [KW-1:0]    stg_rev   [CAP+1];
    logic [KW-1:0]    stg_best  [CAP+1];

    dmc_prep #(
        .CAP   (CAP),
        .LEN_W (LEN_W),
        .KW    (KW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_bases  (s_motif_bases),
        .in_length (s_motif_length),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_len   (stg_len[0]),
        .out_empty (stg_empty[0]),
        .out_fwd   (stg_fwd[0]),
        .out_rev   (stg_rev[0])
    );

    // Every candidate is no larger than all ones, so the first cell takes one whenever the length is non-zero.
    assign stg_best[0] = '1;

    for (genvar k = 0; k < CAP; k++) begin : g_cell
        dmc_cell #(
            .K     (k),
            .CAP   (CAP),
            .LEN_W (LEN_W),
            .KW    (KW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_len    (stg_len[k]),
            .in_empty  (stg_empty[k]),
            .in_fwd    (stg_fwd[k]),
            .in_rev    (stg_rev[k]),
            .in_best   (stg_best[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_len   (stg_len[k+1]),
            .out_empty (stg_empty[k+1]),
            .out_fwd   (stg_fwd[k+1]),
            .out_rev   (stg_rev[k+1]),
            .out_best  (stg_best[k+1])
        );
    end

    assign stg_ready[CAP] = m_ready;
    assign m_valid        = stg_valid[CAP];
    assign m_empty_motif  = stg_empty[CAP];

    // The key has its first base at the top; the port wants it at the bottom.
    always_comb begin
        m_canonical_bases = '0;
        if (!stg_empty[CAP]) begin
            for (int i = 0; i < CAP; i++) begin
                m_canonical_bases[BASE_W*i +: BASE_W] = stg_best[CAP][KW-1-BASE_W*i -: BASE_W];
            end
        end
    end

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_motif |-> m_canonical_bases == '0)
        else $error("empty motif gave non-zero bases");

    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (stg_empty[CAP] == (stg_len[CAP] == '0)))
        else $error("empty flag disagrees with carried length");

    a_prep_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid[0] && !stg_ready[0] |=> stg_valid[0] && $stable(stg_fwd[0]))
        else $error("preparation stage lost a stalled word");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid[0] |-> stg_len[0] <= LEN_W'(CAP))
        else $error("length not saturated to capacity");

endmodule
